// ===== hdl/dual_wheel_encoder_pid_drive_macros.svh =====
// assertion macros for the dual wheel encoder pid drive
// every use needs clk and rst in scope
`ifndef DUAL_WHEEL_ENCODER_PID_DRIVE_MACROS_SVH
`define DUAL_WHEEL_ENCODER_PID_DRIVE_MACROS_SVH

// same-cycle implication
`define DWE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dwe_pkg.sv =====
// shared constants, types and beat layouts of the wheel drive block
// no dependencies
package dwe_pkg;

  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS  = 14;
  localparam int DRIVE_MAX  = 255;

  localparam int GOAL_W    = 24;
  localparam int PROG_W    = COUNT_BITS + 1;
  localparam int CMP_W     = ((PROG_W > GOAL_W) ? PROG_W : GOAL_W) + 2;
  localparam int REM_W     = GOAL_W + 1;
  localparam int RATIO_W   = FRAC_BITS + 2;
  localparam int ERR_W     = FRAC_BITS + 3;
  localparam int DER_W     = ERR_W + 1;
  localparam int SUM_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int K_W       = GAIN_W + 6;
  localparam int OPND_W    = SUM_W + 1;
  localparam int PROD_W    = K_W + 1 + OPND_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int NUM_W     = ACC_W + 1;
  localparam int DRV_SHIFT = FRAC_BITS + 8;
  localparam int STEP_W    = $clog2(FRAC_BITS + 1);
  localparam int SPEED_W   = 8;
  localparam int DRV_W     = 9;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_MOVING = 2 * DRV_W;
  localparam int OUT_FIN    = 2 * DRV_W + 1;
  localparam int OUT_WALL   = 2 * DRV_W + 2;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_LEFT  = 2'd1;
  localparam logic [1:0] OP_RIGHT = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WALL = 3'd5;

  typedef logic signed [CMP_W-1:0] cmp_t;

  typedef struct packed {
    logic              start;
    logic [CMP_W-1:0]  prog;
    logic [GOAL_W-1:0] goal;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [RATIO_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [K_W-1:0]    k_p;
    logic [K_W-1:0]    k_i;
    logic [K_W-1:0]    k_d;
    logic [ERR_W-1:0]  err;
    logic [SUM_W-1:0]  sum;
    logic [DER_W-1:0]  der;
  } mac_req_t;

  typedef struct packed {
    logic             done;
    logic [ACC_W-1:0] acc;
  } mac_rsp_t;

endpackage

// ===== hdl/dual_wheel_encoder_pid_drive.sv =====
// Differential drive controller: counts encoder edges per wheel and, on each
// control tick of a move, runs a pid on the progress difference to set both
// wheel drives. Start, edge and idle or stopping ticks go straight to the result
// register. A tick that updates the pid first has the shared divider form each
// wheel's progress ratio one bit a cycle, left then right, then runs the shared
// multiply-accumulate and sets both drives before the result register. s_tready
// is high only while the sequencer is idle; the result register lets a new beat
// in while a result still waits. Configuration writes are always ready.
// Top level; depends on dwe_pkg, dwe_div, dwe_mac.
module dual_wheel_encoder_pid_drive (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // target_left[23:0], target_right[47:24], use_wall_sensor[48],
  // phase_b_level[49], front_distance_cm[57:50], zero pad
  input  logic [dwe_pkg::IN_DATA_W-1:0]       s_tdata,
  // op[1:0]
  input  logic [1:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // drive_left[8:0], drive_right[17:9], moving[18], finished[19],
  // wall_stop[20], zero pad
  output logic [dwe_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dwe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dwe_pkg::GAIN_W-1:0]          cfg_data
);
  import dwe_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DIV0 = 7'b0000010,
    S_DIV1 = 7'b0000100,
    S_PID  = 7'b0001000,
    S_MAC  = 7'b0010000,
    S_DRV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state;

  logic [K_W-1:0]        kp50, ki50, kd50;
  logic [SPEED_W-1:0]    base_speed, max_speed, wall_limit;

  logic [COUNT_BITS-1:0] left_count, right_count;
  logic [GOAL_W-1:0]     left_goal, right_goal;
  logic                  left_reverse, right_reverse;
  logic                  sensor_enabled, active;
  logic [SUM_W-1:0]      error_sum;
  logic [ERR_W-1:0]      last_error, err_cur;
  logic [DER_W-1:0]      der_cur;
  logic [RATIO_W-1:0]    ratio_l, ratio_r;
  logic [DRV_W-1:0]      left_hold, right_hold;
  logic                  fin_r, wall_r;

  logic                  accept;
  logic [GOAL_W-1:0]     tl, tr;
  cmp_t                  pl, pr;
  logic                  lok, rok, wall_now, stop_now;
  logic [ERR_W-1:0]      err_now;
  logic [DER_W-1:0]      der_now;
  logic [SUM_W:0]        sum_wide;
  logic [SUM_W-1:0]      sum_next;
  logic [SPEED_W-1:0]    lim;
  logic signed [NUM_W-1:0] base_ext, acc_ext, numer_l, numer_r;

  div_req_t div_req;
  div_rsp_t div_rsp;
  mac_req_t mac_req;
  mac_rsp_t mac_rsp;

  function automatic logic [K_W-1:0] gain50(input logic [GAIN_W-1:0] g);
    logic [K_W-1:0] x;
    x = K_W'(g);
    return (x << 5) + (x << 4) + (x << 1);
  endfunction

  function automatic logic [DRV_W-1:0] wheel_drive(input logic signed [NUM_W-1:0] numer,
                                                   input logic done, input logic rev,
                                                   input logic [SPEED_W-1:0] lim_in);
    logic signed [NUM_W-1:0] d;
    logic [SPEED_W-1:0]      mag;
    d = numer >>> DRV_SHIFT;
    if (done || numer <= 0) mag = '0;
    else if (d > $signed(NUM_W'(lim_in))) mag = lim_in;
    else mag = d[SPEED_W-1:0];
    return rev ? -{1'b0, mag} : {1'b0, mag};
  endfunction

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign tl        = s_tdata[23:0];
  assign tr        = s_tdata[47:24];

  // signed progress of each wheel and stop conditions
  always_comb begin
    pl = cmp_t'($signed(left_count));
    pr = cmp_t'($signed(right_count));
    if (left_reverse) pl = -pl;
    if (right_reverse) pr = -pr;
    lok      = pl >= $signed(CMP_W'(left_goal));
    rok      = pr >= $signed(CMP_W'(right_goal));
    wall_now = sensor_enabled && (s_tdata[57:50] < wall_limit);
    stop_now = (lok && rok) || wall_now;
  end

  always_comb begin
    err_now  = {1'b0, ratio_l} - {1'b0, ratio_r};
    der_now  = {err_now[ERR_W-1], err_now} - {last_error[ERR_W-1], last_error};
    sum_wide = {error_sum[SUM_W-1], error_sum}
             + {{(SUM_W+1-ERR_W){err_now[ERR_W-1]}}, err_now};
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
      sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    else
      sum_next = sum_wide[SUM_W-1:0];
  end

  always_comb begin
    lim      = (32'(max_speed) < DRIVE_MAX) ? max_speed : SPEED_W'(DRIVE_MAX);
    base_ext = $signed(NUM_W'(base_speed)) <<< DRV_SHIFT;
    acc_ext  = NUM_W'($signed(mac_rsp.acc));
    numer_l  = base_ext - acc_ext;
    numer_r  = base_ext + acc_ext;
  end

  always_comb begin
    div_req.start = (state == S_IDLE && accept && s_tuser == OP_TICK && active && !stop_now)
                 || (state == S_DIV0 && div_rsp.done);
    div_req.prog  = (state == S_DIV0) ? pr : pl;
    div_req.goal  = (state == S_DIV0) ? right_goal : left_goal;
  end

  always_comb begin
    mac_req.start = (state == S_PID);
    mac_req.k_p   = kp50;
    mac_req.k_i   = ki50;
    mac_req.k_d   = kd50;
    mac_req.err   = err_cur;
    mac_req.sum   = error_sum;
    mac_req.der   = der_cur;
  end

  dwe_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));
  dwe_mac u_mac (.clk(clk), .rst(rst), .req(mac_req), .rsp(mac_rsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      kp50 <= gain50(GAIN_W'(256));
      ki50 <= '0;
      kd50 <= '0;
      base_speed <= SPEED_W'(150);
      max_speed  <= SPEED_W'(255);
      wall_limit <= SPEED_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KP:   kp50 <= gain50(cfg_data);
        REG_KI:   ki50 <= gain50(cfg_data);
        REG_KD:   kd50 <= gain50(cfg_data);
        REG_BASE: base_speed <= cfg_data[SPEED_W-1:0];
        REG_MAX:  max_speed  <= cfg_data[SPEED_W-1:0];
        REG_WALL: wall_limit <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      left_count     <= '0;
      right_count    <= '0;
      left_goal      <= '0;
      right_goal     <= '0;
      left_reverse   <= 1'b0;
      right_reverse  <= 1'b0;
      sensor_enabled <= 1'b0;
      active         <= 1'b0;
      error_sum      <= '0;
      last_error     <= '0;
      left_hold      <= '0;
      right_hold     <= '0;
      fin_r          <= 1'b0;
      wall_r         <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tready && state != S_OUT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fin_r  <= 1'b0;
            wall_r <= 1'b0;
            state  <= S_OUT;
            case (s_tuser)
              OP_START: begin
                left_reverse   <= tl[GOAL_W-1];
                right_reverse  <= tr[GOAL_W-1];
                left_goal      <= tl[GOAL_W-1] ? -tl : tl;
                right_goal     <= tr[GOAL_W-1] ? -tr : tr;
                left_count     <= '0;
                right_count    <= '0;
                error_sum      <= '0;
                last_error     <= '0;
                sensor_enabled <= s_tdata[48];
                active         <= 1'b1;
                left_hold      <= '0;
                right_hold     <= '0;
              end
              OP_LEFT: begin
                left_count <= s_tdata[49] ? left_count - COUNT_BITS'(1)
                                          : left_count + COUNT_BITS'(1);
              end
              OP_RIGHT: begin
                right_count <= s_tdata[49] ? right_count + COUNT_BITS'(1)
                                           : right_count - COUNT_BITS'(1);
              end
              default: begin
                if (active) begin
                  if (stop_now) begin
                    active     <= 1'b0;
                    fin_r      <= 1'b1;
                    wall_r     <= wall_now;
                    left_hold  <= '0;
                    right_hold <= '0;
                  end else begin
                    state <= S_DIV0;
                  end
                end
              end
            endcase
          end
        end
        S_DIV0: begin
          if (div_rsp.done) begin
            ratio_l <= div_rsp.quot;
            state   <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (div_rsp.done) begin
            ratio_r <= div_rsp.quot;
            state   <= S_PID;
          end
        end
        S_PID: begin
          err_cur    <= err_now;
          der_cur    <= der_now;
          error_sum  <= sum_next;
          last_error <= err_now;
          state      <= S_MAC;
        end
        S_MAC: begin
          if (mac_rsp.done) state <= S_DRV;
        end
        S_DRV: begin
          left_hold  <= wheel_drive(numer_l, lok, left_reverse, lim);
          right_hold <= wheel_drive(numer_r, rok, right_reverse, lim);
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_DATA_W-OUT_WALL-1){1'b0}}, wall_r, fin_r, active,
                         right_hold, left_hold};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/dwe_div.sv =====
// restoring divider, one quotient bit a cycle, gives a wheel progress ratio
// depends on dwe_pkg
module dwe_div (
  input  logic              clk,
  input  logic              rst,
  input  dwe_pkg::div_req_t req,
  output dwe_pkg::div_rsp_t rsp
);
  import dwe_pkg::*;

  logic                 busy;
  logic                 done;
  logic [STEP_W-1:0]    cnt;
  logic [REM_W-1:0]     rem;
  logic [REM_W-1:0]     goal_r;
  logic [FRAC_BITS-1:0] quot;
  logic [RATIO_W-1:0]   result;
  logic [REM_W:0]       diff;
  logic                 qbit;
  logic [REM_W-1:0]     rem_keep;
  cmp_t                 prog;
  cmp_t                 goal2;

  assign prog     = cmp_t'(req.prog);
  assign goal2    = cmp_t'({req.goal, 1'b0});
  assign diff     = {1'b0, rem} - {1'b0, goal_r};
  assign qbit     = !diff[REM_W];
  assign rem_keep = qbit ? diff[REM_W-1:0] : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (req.goal == '0) begin
          result <= RATIO_W'(1) << FRAC_BITS;
          done   <= 1'b1;
        end else if (prog <= 0) begin
          result <= '0;
          done   <= 1'b1;
        end else if (prog >= goal2) begin
          result <= RATIO_W'(1) << (FRAC_BITS + 1);
          done   <= 1'b1;
        end else begin
          busy   <= 1'b1;
          rem    <= prog[REM_W-1:0];
          goal_r <= {1'b0, req.goal};
          cnt    <= '0;
          quot   <= '0;
        end
      end else if (busy) begin
        quot <= {quot[FRAC_BITS-2:0], qbit};
        rem  <= {rem_keep[REM_W-2:0], 1'b0};
        cnt  <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(FRAC_BITS)) begin
          busy   <= 1'b0;
          done   <= 1'b1;
          result <= {1'b0, quot, qbit};
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = result;

endmodule

// ===== hdl/dwe_mac.sv =====
// shared multiply-accumulate for the three pid terms, one product a cycle
// depends on dwe_pkg
module dwe_mac (
  input  logic              clk,
  input  logic              rst,
  input  dwe_pkg::mac_req_t req,
  output dwe_pkg::mac_rsp_t rsp
);
  import dwe_pkg::*;

  localparam logic [1:0] TERMS = 2'd3;

  logic                      busy;
  logic                      pv;
  logic                      done;
  logic [1:0]                cnt;
  logic [K_W-1:0]            k_sel;
  logic [OPND_W-1:0]         x_sel;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;

  always_comb begin
    case (cnt)
      2'd0: begin
        k_sel = req.k_p;
        x_sel = {{(OPND_W-ERR_W){req.err[ERR_W-1]}}, req.err};
      end
      2'd1: begin
        k_sel = req.k_i;
        x_sel = {{(OPND_W-SUM_W){req.sum[SUM_W-1]}}, req.sum};
      end
      default: begin
        k_sel = req.k_d;
        x_sel = {{(OPND_W-DER_W){req.der[DER_W-1]}}, req.der};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pv   <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        pv   <= 1'b0;
        cnt  <= '0;
        acc  <= '0;
      end else if (busy) begin
        if (pv) acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        if (cnt != TERMS) begin
          prod <= $signed({1'b0, k_sel}) * $signed(x_sel);
          pv   <= 1'b1;
          cnt  <= cnt + 2'd1;
        end else begin
          busy <= 1'b0;
          pv   <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.acc  = acc;

endmodule

// ===== hdl/dwe_checker.sv =====
// port-level checks on the result stream of the wheel drive block
// depends on dwe_pkg and the assertion macro header; bound to the top level
`include "dual_wheel_encoder_pid_drive_macros.svh"

module dwe_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [dwe_pkg::OUT_DATA_W-1:0] m_tdata
);
  import dwe_pkg::*;

  `DWE_ASSERT_IMP(a_fin_not_moving, m_tvalid && m_tdata[OUT_FIN], !m_tdata[OUT_MOVING], "finished beat still moving")
  `DWE_ASSERT_IMP(a_wall_needs_fin, m_tvalid && m_tdata[OUT_WALL], m_tdata[OUT_FIN], "wall stop without finish")
  `DWE_ASSERT_IMP(a_idle_zero_drive, m_tvalid && !m_tdata[OUT_MOVING], m_tdata[2*DRV_W-1:0] == '0, "drive while idle")
  `DWE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled beat changed")

endmodule

bind dual_wheel_encoder_pid_drive dwe_checker u_dwe_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

// ===== tb/dual_wheel_encoder_pid_drive_tb.sv =====
// self-checking testbench for the dual wheel encoder pid drive block
// a scoreboard class predicts every result beat, plain tasks drive the ports
// depends on dwe_pkg and the dual_wheel_encoder_pid_drive rtl
module dual_wheel_encoder_pid_drive_tb;
  import dwe_pkg::*;

  class drive_scoreboard;
    logic [15:0] kp, ki, kd;
    logic [7:0] base, max_spd, wall_lim;
    logic [23:0] lcnt, rcnt, lgoal, rgoal;
    bit lrev, rrev, sens, act;
    longint esum, lerr;
    logic signed [8:0] lhold, rhold;
    logic [23:0] expected_beats[$];
    int errors;

    function new();
      kp = 256; ki = 0; kd = 0; base = 150; max_spd = 255; wall_lim = 3;
      lcnt = 0; rcnt = 0; lgoal = 0; rgoal = 0; lrev = 0; rrev = 0;
      sens = 0; act = 0; esum = 0; lerr = 0; lhold = 0; rhold = 0; errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_KP: kp = val;
        REG_KI: ki = val;
        REG_KD: kd = val;
        REG_BASE: base = val[7:0];
        REG_MAX: max_spd = val[7:0];
        REG_WALL: wall_lim = val[7:0];
        default: ;
      endcase
    endfunction

    function longint progress_ratio(longint prog, longint goal);
      longint q;
      if (goal == 0) return longint'(1) << FRAC_BITS;
      if (prog <= 0) return 0;
      q = (prog << FRAC_BITS) / goal;
      return (q > (longint'(1) << (FRAC_BITS + 1))) ? (longint'(1) << (FRAC_BITS + 1)) : q;
    endfunction

    function logic signed [8:0] wheel_speed(longint numer, bit done, bit rev);
      longint lim, d;
      lim = (max_spd < DRIVE_MAX) ? max_spd : DRIVE_MAX;
      if (done || numer <= 0) return 0;
      d = numer >>> (FRAC_BITS + 8);
      if (d > lim) d = lim;
      return rev ? -d : d;
    endfunction

    function void note(logic [1:0] op, logic [63:0] data);
      longint tl, tr, pl, pr, err, der, acc, bnum;
      bit lok, rok, wall, fin;
      fin = 0; wall = 0;
      case (op)
        OP_START: begin
          tl = longint'($signed(data[23:0]));
          tr = longint'($signed(data[47:24]));
          lrev = tl < 0; rrev = tr < 0;
          lgoal = (tl < 0) ? -tl : tl;
          rgoal = (tr < 0) ? -tr : tr;
          lcnt = 0; rcnt = 0; esum = 0; lerr = 0;
          sens = data[48]; act = 1; lhold = 0; rhold = 0;
        end
        OP_LEFT: lcnt = data[49] ? lcnt - 1 : lcnt + 1;
        OP_RIGHT: rcnt = data[49] ? rcnt + 1 : rcnt - 1;
        default: if (act) begin
          pl = longint'($signed(lcnt));
          pr = longint'($signed(rcnt));
          if (lrev) pl = -pl;
          if (rrev) pr = -pr;
          lok = pl >= longint'(lgoal);
          rok = pr >= longint'(rgoal);
          wall = sens && (data[57:50] < wall_lim);
          if ((lok && rok) || wall) begin
            act = 0; fin = 1; lhold = 0; rhold = 0;
          end else begin
            err = progress_ratio(pl, lgoal) - progress_ratio(pr, rgoal);
            der = err - lerr;
            esum += err;
            if (esum > 64'sd2147483647) esum = 64'sd2147483647;
            if (esum < -64'sd2147483648) esum = -64'sd2147483648;
            lerr = err;
            acc = longint'(kp) * err + longint'(ki) * esum + longint'(kd) * der;
            bnum = longint'(base) << (FRAC_BITS + 8);
            lhold = wheel_speed(bnum - 50 * acc, lok, lrev);
            rhold = wheel_speed(bnum + 50 * acc, rok, rrev);
          end
        end
      endcase
      expected_beats.push_back({3'b0, fin & wall, fin, act, rhold, lhold});
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check(logic [23:0] got);
      logic [23:0] want;
      if (expected_beats.size() == 0) begin
        report("unexpected beat", got, 0);
      end else begin
        want = expected_beats.pop_front();
        if (got[8:0] !== want[8:0]) report("drive_left", $signed(got[8:0]), $signed(want[8:0]));
        if (got[17:9] !== want[17:9])
          report("drive_right", $signed(got[17:9]), $signed(want[17:9]));
        if (got[18] !== want[18]) report("moving", got[18], want[18]);
        if (got[19] !== want[19]) report("finished", got[19], want[19]);
        if (got[20] !== want[20]) report("wall_stop", got[20], want[20]);
      end
    endtask
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_valid, cfg_ready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0] cfg_data;

  drive_scoreboard sb;
  bit no_gaps;
  bit hold_req;

  dual_wheel_encoder_pid_drive DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver with random stalls and one long forced hold
  initial begin
    int stall;
    stall = 0;
    m_tready <= 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check(m_tdata);
      if (hold_req) begin
        hold_req = 0;
        stall = 400;
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 0;
      end else begin
        stall = pick_gap();
        m_tready <= (stall == 0);
      end
    end
  end

  task send_item(logic [1:0] op, logic [23:0] tl, logic [23:0] tr, bit ws, bit pb,
                 logic [7:0] front);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {6'b0, front, pb, ws, tr, tl};
    do @(posedge clk); while (!s_tready);
    sb.note(op, {6'b0, front, pb, ws, tr, tl});
  endtask

  task drain();
    s_tvalid <= 0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task load_regs(logic [15:0] p, logic [15:0] i, logic [15:0] d, logic [7:0] b,
                 logic [7:0] m, logic [7:0] w);
    write_reg(REG_KP, p);
    write_reg(REG_KI, i);
    write_reg(REG_KD, d);
    write_reg(REG_BASE, b);
    write_reg(REG_MAX, m);
    write_reg(REG_WALL, w);
  endtask

  // one move: start, then edges mostly in the target direction and ticks
  task random_move(int steps);
    logic [23:0] tl, tr;
    logic [1:0] op;
    bit pb;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      tl = $urandom; tr = $urandom;
    end else if (r == 1) begin
      tl = 0; tr = $signed($urandom_range(0, 10)) - 5;
    end else begin
      tl = $signed($urandom_range(0, 60)) - 30;
      tr = $signed($urandom_range(0, 60)) - 30;
    end
    send_item(OP_START, tl, tr, $urandom_range(0, 1), $urandom_range(0, 1), $urandom);
    repeat (steps) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (r < 68) begin
        op = (r < 38) ? OP_LEFT : OP_RIGHT;
        pb = (op == OP_LEFT) ? tl[23] : !tr[23];
        if ($urandom_range(0, 4) == 0) pb = !pb;
        send_item(op, $urandom, $urandom, $urandom, pb, $urandom);
      end else begin
        send_item(OP_TICK, $urandom, $urandom, $urandom, $urandom,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : $urandom);
      end
    end
  endtask

  task random_phase(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      no_gaps = ($urandom_range(0, 5) == 0);
      random_move($urandom_range(5, 30));
      sent += 20;
    end
    no_gaps = 0;
    drain();
  endtask

  initial begin
    sb = new();
    no_gaps = 0;
    hold_req = 0;
    rst <= 1;
    s_tvalid <= 0;
    s_tdata <= 0;
    s_tuser <= OP_TICK;
    cfg_valid <= 0;
    cfg_index <= REG_KP;
    cfg_data <= 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: idle tick, idle edges, extreme targets, wall stop, restart
    send_item(OP_TICK, 0, 0, 0, 0, 8'd0);
    send_item(OP_LEFT, 0, 0, 0, 1, 0);
    send_item(OP_RIGHT, 0, 0, 0, 0, 0);
    send_item(OP_START, 24'h800000, 24'h7fffff, 1, 0, 8'hff);
    send_item(OP_LEFT, 24'hffffff, 24'hffffff, 1, 1, 8'hff);
    send_item(OP_RIGHT, 0, 0, 0, 1, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 8'hff);
    send_item(OP_TICK, 24'hffffff, 24'hffffff, 1, 1, 8'd3);
    send_item(OP_TICK, 0, 0, 0, 0, 8'd2);
    send_item(OP_TICK, 0, 0, 0, 0, 8'd0);
    send_item(OP_START, 0, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 8'd0);
    send_item(OP_START, 24'd2, 24'hfffffe, 0, 0, 0);
    send_item(OP_LEFT, 0, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 8'd0);
    send_item(OP_START, 24'd1, 24'hffffff, 0, 0, 0);
    send_item(OP_LEFT, 0, 0, 0, 0, 0);
    send_item(OP_RIGHT, 0, 0, 0, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 8'd0);
    send_item(OP_START, 24'd5, 24'd5, 1, 0, 0);
    send_item(OP_TICK, 0, 0, 0, 0, 8'd200);
    drain();

    random_phase(100);

    load_regs(16'hffff, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff);
    // receiver holds off while the sender keeps offering beats
    hold_req = 1;
    no_gaps = 1;
    random_move(40);
    no_gaps = 0;
    drain();
    random_phase(80);

    load_regs(0, 0, 0, 0, 0, 0);
    random_phase(80);

    load_regs(16'd300, 16'd20, 16'd500, 8'd120, 8'd200, 8'd10);
    random_phase(120);

    load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(120);

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
